/* rtl/euler_to_quaternion_assert.svh */
// Assertion macros shared by the euler_to_quaternion checker.
// Depends on nothing; the including module supplies clock and reset.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define E2Q_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("e2q check failed");

// Check that a condition in one cycle implies another in the next
`define E2Q_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("e2q check failed");

`endif

/* rtl/e2q_pkg.sv */
// Types, constants and fixed-point helpers for the Euler to quaternion block.
// Used by every module of the block; depends on nothing.
package e2q_pkg;

   localparam int ATAN_LEN = 24;

   // CORDIC constants in signed Q2.30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
   localparam logic signed [33:0] HALF_PI     = 34'sh06487ED51;
   localparam logic signed [33:0] PI          = 34'sh0C90FDAA2;
   localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

   // atan(2^-i) in Q2.30, truncated
   localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
      32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
      32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
      32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic signed [15:0] angle_psi;
      logic signed [15:0] angle_phi;
      logic signed [15:0] angle_theta;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   // One CORDIC rotation in flight
   typedef struct packed {
      logic               flip;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } lane_type;

   // Lane 0 psi, lane 1 phi, lane 2 theta
   typedef struct packed {
      lane_type [2:0] lane;
   } triple_type;

   // Q2.30 product, rounded half up
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] p;
      logic signed [63:0] r;
      p = 64'(a) * 64'(b);
      r = (p + 64'sd536870912) >>> 30;
      return r[31:0];
   endfunction

   // Round Q2.30 to Q2.14 and saturate to plus or minus one
   function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
      logic signed [33:0] r;
      logic signed [17:0] n;
      r = (v + 34'sd32768) >>> 16;
      n = r[17:0];
      if (n > ONE_Q14) begin
         n = ONE_Q14;
      end else if (n < -ONE_Q14) begin
         n = -ONE_Q14;
      end
      return n[15:0];
   endfunction

endpackage

/* rtl/e2q_fold.sv */
// Input stage: halves the angles and folds them into the CORDIC range.
// Depends on e2q_pkg.
module e2q_fold (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  e2q_pkg::req_type    up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output e2q_pkg::triple_type dn_data
);
   import e2q_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   triple_type data_ff;
   triple_type data_in;
   logic signed [15:0] ang [3];

   assign ang[0] = up_data.angle_psi;
   assign ang[1] = up_data.angle_phi;
   assign ang[2] = up_data.angle_theta;

   // Half-angle in Q2.30 is the Q3.13 angle shifted by 16; fold by pi
   always_comb begin
      logic signed [33:0] z;
      for (int k = 0; k < 3; k++) begin
         z = {{2{ang[k][15]}}, ang[k], 16'h0000};
         data_in.lane[k].x = CORDIC_GAIN;
         data_in.lane[k].y = '0;
         if (z > HALF_PI) begin
            data_in.lane[k].z    = z - PI;
            data_in.lane[k].flip = 1'b1;
         end else if (z < -HALF_PI) begin
            data_in.lane[k].z    = z + PI;
            data_in.lane[k].flip = 1'b1;
         end else begin
            data_in.lane[k].z    = z;
            data_in.lane[k].flip = 1'b0;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // Advance when the next stage has room
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
endmodule

/* rtl/e2q_cordic_cell.sv */
// One CORDIC rotation cell, applied to all three angle lanes at once.
// Depends on e2q_pkg.
module e2q_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  e2q_pkg::triple_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output e2q_pkg::triple_type dn_data
);
   import e2q_pkg::*;

   localparam logic signed [33:0] ATAN = {2'b00, ATAN_TABLE[SHIFT]};

   logic       valid_ff;
   logic       valid_in;
   triple_type data_ff;
   triple_type data_in;

   // Rotate towards zero residual angle
   always_comb begin
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      for (int k = 0; k < 3; k++) begin
         dx = up_data.lane[k].y >>> SHIFT;
         dy = up_data.lane[k].x >>> SHIFT;
         data_in.lane[k].flip = up_data.lane[k].flip;
         if (!up_data.lane[k].z[33]) begin
            data_in.lane[k].x = up_data.lane[k].x - dx;
            data_in.lane[k].y = up_data.lane[k].y + dy;
            data_in.lane[k].z = up_data.lane[k].z - ATAN;
         end else begin
            data_in.lane[k].x = up_data.lane[k].x + dx;
            data_in.lane[k].y = up_data.lane[k].y - dy;
            data_in.lane[k].z = up_data.lane[k].z + ATAN;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // Hand the lanes to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;
endmodule

/* rtl/e2q_combine.sv */
// Combines the three cosine/sine pairs into the quaternion: three stages.
// Depends on e2q_pkg.
module e2q_combine (
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   output logic                up_ready,
   input  e2q_pkg::triple_type up_data,
   output logic                dn_valid,
   input  logic                dn_ready,
   output e2q_pkg::rsp_type    dn_data
);
   import e2q_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;
   logic signed [31:0] c [3];
   logic signed [31:0] s [3];
   logic signed [31:0] p_ff [4];   // cc, ss, sc, cs
   logic signed [31:0] cps_ff, sps_ff;
   logic signed [31:0] t_ff [8];
   rsp_type            q_ff;

   // Undo the fold by negating cosine and sine
   always_comb begin
      logic signed [33:0] xv;
      logic signed [33:0] yv;
      for (int k = 0; k < 3; k++) begin
         xv = up_data.lane[k].flip ? -up_data.lane[k].x : up_data.lane[k].x;
         yv = up_data.lane[k].flip ? -up_data.lane[k].y : up_data.lane[k].y;
         c[k] = xv[31:0];
         s[k] = yv[31:0];
      end
   end

   assign rdy3     = !v3_ff || dn_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign up_ready = rdy1;

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= up_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Pair products of phi and theta
   always_ff @(posedge clock) begin
      if (rdy1 && up_valid) begin
         p_ff[0] <= mul_q30(c[1], c[2]);
         p_ff[1] <= mul_q30(s[1], s[2]);
         p_ff[2] <= mul_q30(s[1], c[2]);
         p_ff[3] <= mul_q30(c[1], s[2]);
         cps_ff  <= c[0];
         sps_ff  <= s[0];
      end
   end

   // Three-factor terms
   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         t_ff[0] <= mul_q30(p_ff[0], cps_ff);
         t_ff[1] <= mul_q30(p_ff[1], sps_ff);
         t_ff[2] <= mul_q30(p_ff[0], sps_ff);
         t_ff[3] <= mul_q30(p_ff[1], cps_ff);
         t_ff[4] <= mul_q30(p_ff[2], cps_ff);
         t_ff[5] <= mul_q30(p_ff[3], sps_ff);
         t_ff[6] <= mul_q30(p_ff[3], cps_ff);
         t_ff[7] <= mul_q30(p_ff[2], sps_ff);
      end
   end

   // Sum, round and saturate
   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         q_ff.quat_w <= to_q14(34'(t_ff[0]) + 34'(t_ff[1]));
         q_ff.quat_x <= to_q14(34'(t_ff[2]) - 34'(t_ff[3]));
         q_ff.quat_y <= to_q14(34'(t_ff[4]) - 34'(t_ff[5]));
         q_ff.quat_z <= to_q14(34'(t_ff[6]) + 34'(t_ff[7]));
      end
   end

   assign dn_valid = v3_ff;
   assign dn_data  = q_ff;
endmodule

/* rtl/euler_to_quaternion.sv */
// Euler angles to unit quaternion: fold stage, a chain of CORDIC cells, combine.
// Throughput one transfer per cycle while rsp_ready is high; every stage has its own valid bit, so
// bubbles close up while the result waits to be taken.
// Synchronous active-high reset empties the pipeline; no other state.
module euler_to_quaternion #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  e2q_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output e2q_pkg::rsp_type rsp_data
);
   import e2q_pkg::*;

   logic       vld [CORDIC_STAGES+1];
   logic       rdy [CORDIC_STAGES+1];
   triple_type dat [CORDIC_STAGES+1];

   e2q_fold u_fold (
      .clock, .reset,
      .up_valid (req_valid), .up_ready (req_ready), .up_data (req_data),
      .dn_valid (vld[0]),    .dn_ready (rdy[0]),    .dn_data (dat[0])
   );

   // Chain of rotation cells
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      e2q_cordic_cell #(.SHIFT(i)) u_cell (
         .clock, .reset,
         .up_valid (vld[i]),   .up_ready (rdy[i]),   .up_data (dat[i]),
         .dn_valid (vld[i+1]), .dn_ready (rdy[i+1]), .dn_data (dat[i+1])
      );
   end

   e2q_combine u_combine (
      .clock, .reset,
      .up_valid (vld[CORDIC_STAGES]), .up_ready (rdy[CORDIC_STAGES]),
      .up_data  (dat[CORDIC_STAGES]),
      .dn_valid (rsp_valid), .dn_ready (rsp_ready), .dn_data (rsp_data)
   );
endmodule

/* rtl/e2q_checker.sv */
// Port-level checks for euler_to_quaternion, bound to the top level.
// Depends on e2q_pkg and euler_to_quaternion_assert.svh.
`include "euler_to_quaternion_assert.svh"
module e2q_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input e2q_pkg::rsp_type rsp_data
);
   import e2q_pkg::*;

   // A stalled result holds
   `E2Q_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // Components stay within plus or minus one
   `E2Q_ASSERT_ALWAYS(a_wx_range, !rsp_valid || (rsp_data.quat_w <= 16'sd16384 && rsp_data.quat_w >= -16'sd16384 && rsp_data.quat_x <= 16'sd16384 && rsp_data.quat_x >= -16'sd16384))
   `E2Q_ASSERT_ALWAYS(a_yz_range, !rsp_valid || (rsp_data.quat_y <= 16'sd16384 && rsp_data.quat_y >= -16'sd16384 && rsp_data.quat_z <= 16'sd16384 && rsp_data.quat_z >= -16'sd16384))
   // A unit quaternion never rounds to all zeros
   `E2Q_ASSERT_ALWAYS(a_nonzero, !rsp_valid || rsp_data != '0)
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data
);
